[hdl/lfmc_pkg.sv]
// Shared constants, types and command/status bundles of the LED flash mode controller.
`default_nettype none
package lfmc_pkg;

	localparam int LED_COUNT   = 96;
	localparam int GROUP_COUNT = (LED_COUNT + 3) / 4;
	localparam int GROUP_W     = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
	localparam int LED_CMP_W   = $clog2(LED_COUNT + 1) + 1;
	localparam int CNT_W       = 16;
	localparam int MODE_W      = 3;
	localparam int CFG_IDX_W   = 2;

	localparam logic [MODE_W-1:0] MODE_OFF    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ON     = 3'd1;
	localparam logic [MODE_W-1:0] MODE_FLASH1 = 3'd2;
	localparam logic [MODE_W-1:0] MODE_FLASH2 = 3'd3;
	localparam logic [MODE_W-1:0] MODE_FLASH3 = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_FLASH1_PERIOD   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FLASH2_PERIOD   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FLASH3_ON_TIME  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FLASH3_OFF_TIME = 2'd3;

	localparam logic [CNT_W-1:0] RST_FLASH1_PERIOD   = 16'd500;
	localparam logic [CNT_W-1:0] RST_FLASH2_PERIOD   = 16'd250;
	localparam logic [CNT_W-1:0] RST_FLASH3_ON_TIME  = 16'd100;
	localparam logic [CNT_W-1:0] RST_FLASH3_OFF_TIME = 16'd900;
	localparam logic [CNT_W-1:0] CNT_MAX             = 16'hFFFF;

	localparam logic [7:0] SLOT_MASK       = 8'h03;
	localparam logic [7:0] GROUP_BASE_MASK = 8'hFC;

	typedef logic [3:0][MODE_W-1:0] mode_row_t;
	typedef logic [3:0]             val_row_t;

	typedef struct packed {
		logic capture;
		logic set_write;
		logic gen_step;
		logic row_update;
		logic row_next;
		logic load_set;
		logic load_walk;
	} dp_cmd_t;

	typedef struct packed {
		logic in_range;
		logic followed;
		logic row_end;
		logic row_flashing;
		logic out_free;
	} dp_stat_t;

endpackage
`default_nettype wire

[hdl/led_flash_mode_controller_core.sv]
// Top level of the LED flash mode controller: controller plus datapath.
//
//   channel  direction  handshake            payload
//   input    in         in_valid / in_stall  kind, led_index, mode
//   result   out        out_valid / out_stall group_index, group_bits, last
//   config   in         cfg_wr_en            cfg_index, cfg_data
//
// Set-mode beat: S_SET writes the row, then S_SET_EMIT loads the output register;
// an out-of-range LED goes back to idle from S_SET. Tick beat: S_GEN steps the
// generators and S_SCAN walks all GROUP_COUNT rows; S_EMIT walks them again when
// groups are emitted. A held output beat blocks the next load, and the next
// input is taken after the last.
// Reset clears modes, values, generators and restores the period registers.
`default_nettype none
module led_flash_mode_controller_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           kind,
	input  wire logic [6:0]                     led_index,
	input  wire logic [2:0]                     mode,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [4:0]                          group_index,
	output logic [7:0]                          group_bits,
	output logic                                last,
	input  wire logic                           cfg_wr_en,
	input  wire logic [lfmc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [lfmc_pkg::CNT_W-1:0]     cfg_data
);

	lfmc_pkg::dp_cmd_t  cmd;
	lfmc_pkg::dp_stat_t stat;

	lfmc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.kind     (kind),
		.stat     (stat),
		.cmd      (cmd)
	);

	lfmc_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.led_index   (led_index),
		.mode        (mode),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.group_index (group_index),
		.group_bits  (group_bits),
		.last        (last)
	);

endmodule
`default_nettype wire

[hdl/lfmc_datapath.sv]
// Datapath: LED mode/value rows, flash generators, config registers and output register.
`default_nettype none
module lfmc_datapath (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire lfmc_pkg::dp_cmd_t               cmd,
	output lfmc_pkg::dp_stat_t                   stat,
	input  wire logic                            cfg_wr_en,
	input  wire logic [lfmc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [lfmc_pkg::CNT_W-1:0]      cfg_data,
	input  wire logic [6:0]                      led_index,
	input  wire logic [2:0]                      mode,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [4:0]                           group_index,
	output logic [7:0]                           group_bits,
	output logic                                 last
);

	logic [lfmc_pkg::CNT_W-1:0] period1_q, period2_q, on3_q, off3_q;
	logic [6:0]                  led_q;
	logic [2:0]                  mode_q;
	lfmc_pkg::mode_row_t         mode_row_q [lfmc_pkg::GROUP_COUNT];
	lfmc_pkg::val_row_t          val_row_q  [lfmc_pkg::GROUP_COUNT];
	logic [2:0]                  gen_val_q;
	logic [2:0]                  toggle_q;
	logic [lfmc_pkg::CNT_W-1:0]  cnt_q [3];
	logic                        followed_q;
	logic [lfmc_pkg::GROUP_W-1:0] row_q, last_flash_q;
	logic                        out_valid_q, out_last_q;
	logic [lfmc_pkg::GROUP_W-1:0] out_group_q;
	logic [7:0]                  out_bits_q;

	logic [lfmc_pkg::GROUP_W-1:0] set_row;
	logic [1:0]                   set_lane;
	logic                         set_val;
	lfmc_pkg::mode_row_t          cur_mode;
	lfmc_pkg::val_row_t           cur_val, upd_val;
	logic                         row_follow, row_flash;
	logic [lfmc_pkg::CNT_W-1:0]   limit [3];
	logic [lfmc_pkg::CNT_W-1:0]   inc [3];
	logic [2:0]                   tog;
	logic                         out_free;

	function automatic logic [7:0] pack_row(input lfmc_pkg::val_row_t v);
		logic [7:0] bits;
		bits = 8'h00;
		for (int k = 0; k < 4; k++) begin
			bits = bits | ((8'(v[k]) & lfmc_pkg::SLOT_MASK) << (2 * k));
		end
		return bits;
	endfunction

	assign set_row  = lfmc_pkg::GROUP_W'((8'(led_q) & lfmc_pkg::GROUP_BASE_MASK) >> 2);
	assign set_lane = led_q[1:0];
	assign cur_mode = mode_row_q[row_q];
	assign cur_val  = val_row_q[row_q];
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		set_val = val_row_q[set_row][set_lane];
		unique case (mode_q)
			lfmc_pkg::MODE_OFF:    set_val = 1'b0;
			lfmc_pkg::MODE_ON:     set_val = 1'b1;
			lfmc_pkg::MODE_FLASH1: set_val = gen_val_q[0];
			lfmc_pkg::MODE_FLASH2: set_val = gen_val_q[1];
			lfmc_pkg::MODE_FLASH3: set_val = gen_val_q[2];
			default:               set_val = val_row_q[set_row][set_lane];
		endcase
	end

	always_comb begin
		logic m1, m2, m3;
		upd_val    = cur_val;
		row_follow = 1'b0;
		row_flash  = 1'b0;
		for (int k = 0; k < 4; k++) begin
			m1 = (cur_mode[k] == lfmc_pkg::MODE_FLASH1) && toggle_q[0];
			m2 = (cur_mode[k] == lfmc_pkg::MODE_FLASH2) && toggle_q[1];
			m3 = (cur_mode[k] == lfmc_pkg::MODE_FLASH3) && toggle_q[2];
			if (m1) upd_val[k] = gen_val_q[0];
			if (m2) upd_val[k] = gen_val_q[1];
			if (m3) upd_val[k] = gen_val_q[2];
			row_follow = row_follow | m1 | m2 | m3;
			row_flash  = row_flash | (cur_mode[k] > lfmc_pkg::MODE_ON);
		end
	end

	always_comb begin
		limit[0] = period1_q;
		limit[1] = period2_q;
		limit[2] = gen_val_q[2] ? on3_q : off3_q;
		for (int g = 0; g < 3; g++) begin
			inc[g] = (cnt_q[g] == lfmc_pkg::CNT_MAX) ? cnt_q[g] : cnt_q[g] + 16'd1;
			tog[g] = inc[g] > limit[g];
		end
	end

	always_comb begin
		stat.in_range     = (lfmc_pkg::LED_CMP_W'(led_q) <
		                     lfmc_pkg::LED_CMP_W'(lfmc_pkg::LED_COUNT));
		stat.followed     = followed_q | row_follow;
		stat.row_end      = (row_q == lfmc_pkg::GROUP_W'(lfmc_pkg::GROUP_COUNT - 1));
		stat.row_flashing = row_flash;
		stat.out_free     = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period1_q    <= lfmc_pkg::RST_FLASH1_PERIOD;
			period2_q    <= lfmc_pkg::RST_FLASH2_PERIOD;
			on3_q        <= lfmc_pkg::RST_FLASH3_ON_TIME;
			off3_q       <= lfmc_pkg::RST_FLASH3_OFF_TIME;
			for (int r = 0; r < lfmc_pkg::GROUP_COUNT; r++) begin
				mode_row_q[r] <= '0;
				val_row_q[r]  <= '0;
			end
			gen_val_q    <= '0;
			toggle_q     <= '0;
			for (int g = 0; g < 3; g++) cnt_q[g] <= '0;
			followed_q   <= 1'b0;
			row_q        <= '0;
			last_flash_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					lfmc_pkg::CFG_FLASH1_PERIOD:   period1_q <= cfg_data;
					lfmc_pkg::CFG_FLASH2_PERIOD:   period2_q <= cfg_data;
					lfmc_pkg::CFG_FLASH3_ON_TIME:  on3_q     <= cfg_data;
					lfmc_pkg::CFG_FLASH3_OFF_TIME: off3_q    <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.set_write) begin
				mode_row_q[set_row][set_lane] <= mode_q;
				val_row_q[set_row][set_lane]  <= set_val;
			end
			if (cmd.gen_step) begin
				for (int g = 0; g < 3; g++) cnt_q[g] <= tog[g] ? '0 : inc[g];
				gen_val_q    <= gen_val_q ^ tog;
				toggle_q     <= tog;
				followed_q   <= 1'b0;
				row_q        <= '0;
				last_flash_q <= '0;
			end
			if (cmd.row_update) begin
				val_row_q[row_q] <= upd_val;
				followed_q       <= followed_q | row_follow;
				if (row_flash) last_flash_q <= row_q;
			end
			if (cmd.row_next) begin
				row_q <= stat.row_end ? '0 : row_q + 1'b1;
			end
			if (cmd.load_set || cmd.load_walk) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			led_q  <= led_index;
			mode_q <= mode;
		end
		if (cmd.load_set) begin
			out_group_q <= set_row;
			out_bits_q  <= pack_row(val_row_q[set_row]);
			out_last_q  <= 1'b1;
		end else if (cmd.load_walk) begin
			out_group_q <= row_q;
			out_bits_q  <= pack_row(cur_val);
			out_last_q  <= (row_q == last_flash_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign group_index = 5'(out_group_q);
	assign group_bits  = out_bits_q;
	assign last        = out_last_q;

endmodule
`default_nettype wire

[hdl/lfmc_ctrl.sv]
// Controller state machine: sequences set-mode writes, generator steps and group walks.
`default_nettype none
module lfmc_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               kind,
	input  wire lfmc_pkg::dp_stat_t stat,
	output lfmc_pkg::dp_cmd_t       cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SET,
		S_SET_EMIT,
		S_GEN,
		S_SCAN,
		S_EMIT
	} state_t;

	state_t state_q;
	logic   in_stall_q;
	logic   accept;

	assign accept   = in_valid && !in_stall_q;
	assign in_stall = in_stall_q;

	always_comb begin
		cmd         = '0;
		cmd.capture = accept;
		unique case (state_q)
			S_IDLE:     ;
			S_SET:      cmd.set_write = stat.in_range;
			S_SET_EMIT: cmd.load_set  = stat.out_free;
			S_GEN:      cmd.gen_step  = 1'b1;
			S_SCAN: begin
				cmd.row_update = 1'b1;
				cmd.row_next   = 1'b1;
			end
			S_EMIT: begin
				cmd.load_walk = stat.row_flashing && stat.out_free;
				cmd.row_next  = !stat.row_flashing || stat.out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			in_stall_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q    <= kind ? S_GEN : S_SET;
						in_stall_q <= 1'b1;
					end
				end
				S_SET: begin
					if (stat.in_range) begin
						state_q <= S_SET_EMIT;
					end else begin
						state_q    <= S_IDLE;
						in_stall_q <= 1'b0;
					end
				end
				S_SET_EMIT: begin
					if (stat.out_free) begin
						state_q    <= S_IDLE;
						in_stall_q <= 1'b0;
					end
				end
				S_GEN: state_q <= S_SCAN;
				S_SCAN: begin
					if (stat.row_end) begin
						if (stat.followed) begin
							state_q <= S_EMIT;
						end else begin
							state_q    <= S_IDLE;
							in_stall_q <= 1'b0;
						end
					end
				end
				S_EMIT: begin
					if (stat.row_end && (!stat.row_flashing || stat.out_free)) begin
						state_q    <= S_IDLE;
						in_stall_q <= 1'b0;
					end
				end
				default: begin
					state_q    <= S_IDLE;
					in_stall_q <= 1'b0;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
